[design/assert_macros.svh]
// Assertion macros shared by the console writer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/tcw_pkg.sv]
// Package for the text console writer: op codes, FSM states, command/status structs.
// No dependencies; imported by the controller, datapath and top level.
package tcw_pkg;

   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int CELL_W    = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [ATTR_W-1:0] RESET_COLOUR = 8'h0F;

   typedef enum logic [1:0] {
      OP_PRINT = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } tcw_op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SCROLL,
      ST_BLANK,
      ST_WRITE,
      ST_READ_WAIT,
      ST_RESPOND
   } tcw_state_type;

   typedef struct packed {
      logic accept;
      logic newline;
      logic ptr_clear;
      logic scroll_step;
      logic blank_step;
      logic reset_colour;
      logic write_char;
      logic read_issue;
      logic read_capture;
   } tcw_cmd_type;

   typedef struct packed {
      tcw_op_type op;
      logic       is_newline;
      logic       col_full;
      logic       row_last;
      logic       idx_in_range;
      logic       copy_done;
      logic       blank_done;
   } tcw_status_type;

endpackage

[design/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcw_controller.sv]
// Console writer sequencer: FSM that steps the datapath through each transaction.
// Depends on tcw_pkg.
module tcw_controller import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   tcw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.blank_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.op)
               OP_PRINT: begin
                  if (status.is_newline || status.col_full) begin
                     if (status.row_last)        state_in = ST_SCROLL;
                     else if (status.is_newline) state_in = ST_RESPOND;
                     else                        state_in = ST_WRITE;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
               OP_CLEAR: state_in = ST_BLANK;
               OP_READ:  state_in = status.idx_in_range ? ST_READ_WAIT : ST_RESPOND;
               default:  state_in = ST_RESPOND;
            endcase
         end
         ST_SCROLL: begin
            if (status.copy_done) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (status.blank_done) begin
               if (status.op == OP_PRINT && !status.is_newline) state_in = ST_WRITE;
               else                                             state_in = ST_RESPOND;
            end
         end
         ST_WRITE:     state_in = ST_RESPOND;
         ST_READ_WAIT: state_in = ST_RESPOND;
         ST_RESPOND:   state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESPOND);
      case (state_ff)
         ST_INIT: begin
            cmd.blank_step   = 1'b1;
            cmd.reset_colour = 1'b1;
         end
         ST_IDLE: begin
            cmd.accept = start;
         end
         ST_DECODE: begin
            case (status.op)
               OP_PRINT: begin
                  if (status.is_newline || status.col_full) begin
                     cmd.newline   = 1'b1;
                     cmd.ptr_clear = status.row_last;
                  end
               end
               OP_CLEAR: cmd.ptr_clear  = 1'b1;
               OP_READ:  cmd.read_issue = status.idx_in_range;
               default:  cmd = '0;
            endcase
         end
         ST_SCROLL:    cmd.scroll_step  = 1'b1;
         ST_BLANK:     cmd.blank_step   = 1'b1;
         ST_WRITE:     cmd.write_char   = 1'b1;
         ST_READ_WAIT: cmd.read_capture = 1'b1;
         default:      cmd = '0;
      endcase
   end

endmodule

[design/tcw_datapath.sv]
// Console writer datapath: cursor, colour register, sweep pointer and the cell RAM.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int LINES   = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_cmd_type          cmd,
   output tcw_status_type       status,
   input  logic [OP_W-1:0]      req_op,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [INDEX_W-1:0]   req_cell_index,
   input  logic                 csr_write,
   input  logic [ATTR_W-1:0]    csr_text_colour,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row_out,
   output logic [COL_OUT_W-1:0] rsp_cursor_col_out,
   output logic [CHAR_W-1:0]    rsp_read_char,
   output logic [ATTR_W-1:0]    rsp_read_attr
);

   localparam int CELL_COUNT = COLUMNS * LINES;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int RW         = $clog2(LINES);
   localparam int CW         = $clog2(COLUMNS + 1);

   logic [ATTR_W-1:0]  colour_ff, colour_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      dst_ff;
   tcw_op_type         op_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [CHAR_W-1:0]  rd_char_ff;
   logic [ATTR_W-1:0]  rd_attr_ff;

   logic              copy_done, blank_done, row_last;
   logic [31:0]       char_pos, src_pos, idx_ext, row_ext, col_ext;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   assign copy_done = (ptr_ff == AW'(COPY_COUNT));
   assign blank_done = (ptr_ff == AW'(CELL_COUNT - 1));
   assign row_last  = (row_ff == RW'(LINES - 1));
   assign idx_ext   = 32'(idx_ff);

   assign status.op           = op_ff;
   assign status.is_newline   = (char_ff == NEWLINE_CHAR);
   assign status.col_full     = (col_ff >= CW'(COLUMNS));
   assign status.row_last     = row_last;
   assign status.idx_in_range = (idx_ext < 32'(CELL_COUNT));
   assign status.copy_done    = copy_done;
   assign status.blank_done   = blank_done;

   always_comb begin
      colour_in = csr_write ? csr_text_colour : colour_ff;

      row_in = row_ff;
      col_in = col_ff;
      if (cmd.newline) begin
         col_in = '0;
         if (!row_last) row_in = row_ff + 1'b1;
      end
      if (cmd.write_char) col_in = col_ff + 1'b1;

      ptr_in = ptr_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.blank_step || (cmd.scroll_step && !copy_done)) begin
         ptr_in = ptr_ff + 1'b1;
      end
      pend_in = cmd.scroll_step && !copy_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= RESET_COLOUR;
         row_ff    <= '0;
         col_ff    <= '0;
         ptr_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         colour_ff <= colour_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         ptr_ff    <= ptr_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= ptr_ff;
      if (cmd.accept) begin
         op_ff      <= tcw_op_type'(req_op);
         char_ff    <= req_char_code;
         idx_ff     <= req_cell_index;
         rd_char_ff <= '0;
         rd_attr_ff <= '0;
      end
      if (cmd.read_capture) begin
         rd_char_ff <= rd_data[CHAR_W-1:0];
         rd_attr_ff <= rd_data[CELL_W-1:CHAR_W];
      end
   end

   // cell layout: attribute in the high byte, character in the low byte
   assign char_pos = 32'(row_ff) * 32'(COLUMNS) + 32'(col_ff);
   assign src_pos  = 32'(ptr_ff) + 32'(COLUMNS);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = {colour_ff, BLANK_CHAR};
      if (pend_ff) begin
         // scroll copy lands in the cycle after its read
         wr_en   = 1'b1;
         wr_addr = dst_ff;
         wr_data = rd_data;
      end else if (cmd.blank_step) begin
         wr_en   = 1'b1;
         wr_data = {cmd.reset_colour ? RESET_COLOUR : colour_ff, BLANK_CHAR};
      end else if (cmd.write_char) begin
         wr_en   = 1'b1;
         wr_addr = char_pos[AW-1:0];
         wr_data = {colour_ff, char_ff};
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ext[AW-1:0];
      if (cmd.scroll_step) begin
         rd_en   = !copy_done;
         rd_addr = src_pos[AW-1:0];
      end else if (cmd.read_issue) begin
         rd_en = 1'b1;
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign row_ext = 32'(row_ff);
   assign col_ext = 32'(col_ff);
   assign rsp_cursor_row_out = row_ext[ROW_OUT_W-1:0];
   assign rsp_cursor_col_out = col_ext[COL_OUT_W-1:0];
   assign rsp_read_char      = rd_char_ff;
   assign rsp_read_attr      = rd_attr_ff;

endmodule

[design/text_console_writer.sv]
// Top level of the text console writer: sequencer plus datapath.
// Depends on tcw_pkg, tcw_controller, tcw_datapath (and tcw_ram), assert_macros.svh.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -----------------------------
//   request   req_op, req_char_code, req_cell_index   start && !busy
//   response  rsp_cursor_*, rsp_read_char/attr        rsp_valid, one-cycle strobe
//   csr       csr_text_colour                         csr_valid && csr_ready
//
// After reset the grid is blanked one cell per clock, with busy high throughout.
// A print that scrolls walks the cell RAM: it copies the lower COLUMNS*(LINES-1) cells
// up by one row, then blanks the bottom row.
// The single-port-write cell RAM sets every sweep to one cell per clock.
// The response strobe cannot be held off; busy drops in the cycle after it.
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int LINES   = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   // request transaction
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_op,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [INDEX_W-1:0]   req_cell_index,
   // response transaction
   output logic                 rsp_valid,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row_out,
   output logic [COL_OUT_W-1:0] rsp_cursor_col_out,
   output logic [CHAR_W-1:0]    rsp_read_char,
   output logic [ATTR_W-1:0]    rsp_read_attr,
   // colour register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ATTR_W-1:0]    csr_text_colour
);

   tcw_cmd_type    cmd;
   tcw_status_type status;

   // colour register takes a write any time, including during the init sweep
   assign csr_ready = 1'b1;

   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .LINES   (LINES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .csr_write          (csr_valid && csr_ready),
      .csr_text_colour    (csr_text_colour),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attr      (rsp_read_attr)
   );

   // a response only comes out of a transaction in flight
   `ASSERT_IMPLY(a_rsp_while_busy, clock, reset, rsp_valid, busy, "response strobe while idle")
   // an accepted transaction holds the request side off
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   // one response per transaction, then back to idle
   `ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_valid, !busy && !rsp_valid,
                "not idle after response")

endmodule

[dv/text_console_writer_tb.sv]
// Self-checking testbench for text_console_writer: a console scoreboard plus directed and
// random print, clear and read traffic. Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_tb;
   import tcw_pkg::*;

   // Geometry of the instance under test (RTL defaults).
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;

   // Op code 3 has no name in the package; the block must treat it as a no-op.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Transactions per half phase of random traffic (six phases, two halves each).
   localparam int HALF_PHASE_ITEMS = 140;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_op;
   logic [CHAR_W-1:0]    req_char_code;
   logic [INDEX_W-1:0]   req_cell_index;
   logic                 rsp_valid;
   logic [ROW_OUT_W-1:0] rsp_cursor_row_out;
   logic [COL_OUT_W-1:0] rsp_cursor_col_out;
   logic [CHAR_W-1:0]    rsp_read_char;
   logic [ATTR_W-1:0]    rsp_read_attr;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [ATTR_W-1:0]    csr_text_colour;

   // One response transaction as the block reports it.
   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic [CHAR_W-1:0]    ch;
      logic [ATTR_W-1:0]    attr;
   } console_rsp_type;

   // Console scoreboard: keeps its own copy of the grid, cursor and colour, computes
   // the response of every accepted request and checks responses in order.
   class console_scoreboard;
      logic [CELL_W-1:0] cells [CELLS];
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic [ATTR_W-1:0]    colour;
      console_rsp_type      expected_q [$];
      int mismatches;
      int checked;
      int scrolls;
      int clears;
      int wraps;
      int reads_in;
      int reads_out;

      function new();
         foreach (cells[i]) cells[i] = {RESET_COLOUR, BLANK_CHAR};
         row    = '0;
         col    = '0;
         colour = RESET_COLOUR;
      endfunction

      function void set_colour(logic [ATTR_W-1:0] value);
         colour = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Cursor to the start of the next row; scroll the grid up on the bottom row.
      function void next_row();
         col = '0;
         if (row < ROWS - 1) begin
            row++;
         end else begin
            for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
            for (int c = 0; c < COLS; c++) cells[CELLS - COLS + c] = {colour, BLANK_CHAR};
            scrolls++;
         end
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [INDEX_W-1:0] idx);
         console_rsp_type e;
         e.ch   = '0;
         e.attr = '0;
         if (op == OP_PRINT) begin
            if (ch == NEWLINE_CHAR) begin
               next_row();
            end else begin
               if (col >= COLS) begin
                  next_row();
                  wraps++;
               end
               cells[row * COLS + col] = {colour, ch};
               col++;
            end
         end else if (op == OP_CLEAR) begin
            foreach (cells[i]) cells[i] = {colour, BLANK_CHAR};
            clears++;
         end else if (op == OP_READ) begin
            if (idx < CELLS) begin
               {e.attr, e.ch} = cells[idx];
               reads_in++;
            end else begin
               reads_out++;
            end
         end
         e.row = row;
         e.col = col;
         expected_q.push_back(e);
      endfunction

      function void check_response(console_rsp_type got);
         console_rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with nothing pending: row %0d col %0d %s %02h %02h",
                        got.row, got.col, "char/attr", got.ch, got.attr);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (got.row !== e.row || got.col !== e.col || got.ch !== e.ch || got.attr !== e.attr)
         begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: response %0d: expected row %0d col %0d char %02h attr %02h,",
                        checked, e.row, e.col, e.ch, e.attr);
               $display("       got row %0d col %0d char %02h attr %02h",
                        got.row, got.col, got.ch, got.attr);
            end
         end
      endfunction
   endclass

   console_scoreboard sb = new();
   int n_sent;

   text_console_writer uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attr      (rsp_read_attr),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_colour    (csr_text_colour)
   );

   // 2-unit clock period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor: everything is sampled at the rising edge, before the RTL's own
   // nonblocking updates land, so request, response and CSR transactions are seen
   // exactly as the handshakes define them.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_request(req_op, req_char_code, req_cell_index);
      if (!reset && rsp_valid)
         sb.check_response('{row: rsp_cursor_row_out, col: rsp_cursor_col_out,
                             ch: rsp_read_char, attr: rsp_read_attr});
      if (!reset && csr_valid && csr_ready)
         sb.set_colour(csr_text_colour);
   end

   // Present one request and hold it until the block takes it. On return the
   // transaction was accepted at the current edge; start stays high so a
   // back-to-back request needs no extra edge.
   task automatic send(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                       input logic [INDEX_W-1:0] idx);
      req_op         <= op;
      req_char_code  <= ch;
      req_cell_index <= idx;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every pending response is in and busy is down.
   // The first edge lets the monitor record a request accepted at this very edge.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Colour register write; only called with the block idle.
   task automatic write_colour(input logic [ATTR_W-1:0] value);
      csr_text_colour <= value;
      csr_valid       <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender gaps: mostly none or short, now and then a long one.
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet)   return 0;
      if (r < 60)  return 0;
      if (r < 90)  return $urandom_range(1, 3);
      if (r < 98)  return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly printable text; the rest is any byte, newline included.
   function automatic logic [CHAR_W-1:0] pick_char();
      if ($urandom_range(0, 99) < 85) return CHAR_W'($urandom_range(32, 126));
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // Any value of an index field.
   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
   endfunction

   // Any byte.
   function automatic logic [CHAR_W-1:0] any_byte();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // Reads favor the rows around the cursor, where the writes land; some go
   // anywhere on the grid and some past its end.
   function automatic logic [INDEX_W-1:0] pick_index();
      int r;
      int base;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         base = (sb.row == 0) ? 0 : (sb.row - 1) * COLS;
         return INDEX_W'(base + $urandom_range(0, 2 * COLS - 1));
      end
      if (r < 85) return INDEX_W'($urandom_range(0, CELLS - 1));
      return any_index();
   endfunction

   // Random traffic built from console-like segments: lines of text, most ended by a
   // newline (some long enough to wrap), bursts of reads, clears, the unused op and a little noise.
   // Some segments run back to back with no gaps at all.
   task automatic run_traffic(input int n_items);
      int  done;
      int  kind;
      int  len;
      bit  quiet;
      done = 0;
      while (done < n_items) begin
         quiet = ($urandom_range(0, 3) == 0);
         kind  = $urandom_range(0, 99);
         if (kind < 55) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(COLS - 2, COLS + 10)
                                              : $urandom_range(0, 30);
            repeat (len) begin
               send(OP_PRINT, pick_char(), any_index());
               idle_for(pick_gap(quiet));
               done++;
            end
            if ($urandom_range(0, 4) != 0) begin
               send(OP_PRINT, NEWLINE_CHAR, any_index());
               idle_for(pick_gap(quiet));
               done++;
            end
         end else if (kind < 80) begin
            repeat ($urandom_range(1, 4)) begin
               send(OP_READ, any_byte(), pick_index());
               idle_for(pick_gap(quiet));
               done++;
            end
         end else if (kind < 83) begin
            send(OP_CLEAR, any_byte(), any_index());
            idle_for(pick_gap(quiet));
            done++;
         end else if (kind < 86) begin
            send(OP_UNUSED, any_byte(), any_index());
            idle_for(pick_gap(quiet));
            done++;
         end else begin
            // noise: any op, any byte, any index
            repeat ($urandom_range(1, 3)) begin
               send(OP_W'($urandom_range(0, 3)), any_byte(), any_index());
               idle_for(pick_gap(quiet));
               done++;
            end
         end
      end
   endtask

   // Run limit: far beyond the slowest legal run (every transaction a full-grid
   // clear after a long gap).
   initial begin
      #24_000_000;
      $display("text_console_writer test failed");
      $finish;
   end

   // Colours for the random phases: both extremes plus a few mixed values.
   logic [ATTR_W-1:0] phase_colour [6];

   initial begin
      start           = 1'b0;
      req_op          = OP_PRINT;
      req_char_code   = '0;
      req_cell_index  = '0;
      csr_valid       = 1'b0;
      csr_text_colour = '0;
      reset           = 1'b1;
      n_sent          = 0;
      phase_colour    = '{8'h00, 8'hFF, 8'h1E, 8'hF0, 8'h5A, 8'h00};
      phase_colour[5] = ATTR_W'($urandom_range(0, 255));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the block blanks the whole grid after reset and stays busy meanwhile
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed checks with the reset colour: reset contents, grid corners,
      // reads past the grid, the unused op, byte extremes, newline, clear.
      send(OP_READ,   8'h00, 11'd0);
      send(OP_READ,   8'h00, INDEX_W'(CELLS - 1));
      send(OP_READ,   8'h00, INDEX_W'(CELLS));
      send(OP_READ,   8'hFF, 11'h7FF);
      send(OP_UNUSED, 8'hFF, 11'h7FF);
      send(OP_PRINT,  8'h00, 11'd0);
      send(OP_PRINT,  8'hFF, 11'h7FF);
      send(OP_PRINT,  NEWLINE_CHAR, 11'd0);
      send(OP_PRINT,  8'h41, 11'd0);
      send(OP_READ,   8'h00, 11'd0);
      send(OP_READ,   8'h00, 11'd1);
      send(OP_READ,   8'h00, INDEX_W'(COLS));
      send(OP_READ,   8'h00, INDEX_W'(COLS + 1));
      send(OP_CLEAR,  8'hFF, 11'h7FF);
      send(OP_READ,   8'h00, 11'd0);
      send(OP_READ,   8'h00, INDEX_W'(COLS));
      send(OP_PRINT,  NEWLINE_CHAR, 11'h7FF);
      send(OP_PRINT,  NEWLINE_CHAR, 11'd0);
      send(OP_PRINT,  8'h7E, 11'd0);
      send(OP_READ,   8'h00, INDEX_W'(3 * COLS));

      // Random phases, one colour each. The mid-phase drain makes the sender
      // wait until every pending response has come back.
      foreach (phase_colour[p]) begin
         drain();
         write_colour(phase_colour[p]);
         run_traffic(HALF_PHASE_ITEMS);
         drain();
         run_traffic(HALF_PHASE_ITEMS);
      end

      drain();
      // a few quiet cycles so any stray response is still caught
      repeat (16) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.mismatches += sb.pending();
         $display("ERROR: %0d responses never arrived", sb.pending());
      end

      $display("Sent %0d requests: %0d reads in the grid, %0d past it, %0d clears,",
               n_sent, sb.reads_in, sb.reads_out, sb.clears);
      $display("%0d scrolls, %0d wraps; checked %0d responses over %0d colours, %0d mismatches",
               sb.scrolls, sb.wraps, sb.checked, $size(phase_colour) + 1, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("text_console_writer test passed");
      end else begin
         $display("text_console_writer test failed");
      end
      $finish;
   end

endmodule
